// File: rtl/core/sdspi_pkg.sv
package sdspi_pkg;

  localparam int unsigned MaxBlockBytes = 4096;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_XFER  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    P_IDLE, P_DUMMY, P_CMD0, P_CMD8, P_OCR1, P_CMD55, P_ACMD41, P_OCR2,
    P_CMD16, P_RD_CMD, P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_RD_END,
    P_WR_CMD, P_WR_TOKEN, P_WR_DATA, P_WR_CRC, P_WR_ACK, P_WR_BUSY,
    P_WR_END, P_CMD13
  } phase_e;

  typedef enum logic [1:0] {
    S_FRAME, S_POLL, S_TAIL, S_END
  } sub_e;

  typedef enum logic [3:0] {
    E_NONE, E_CMD0, E_CMD8_CRC, E_CMD8_CHECK, E_OCR, E_CMD55, E_ACMD41,
    E_CMD16, E_READ_R1, E_TOKEN, E_WR_ACK, E_WR_STATUS
  } err_e;

  localparam logic [1:0] StBusy = 2'd0;
  localparam logic [1:0] StOk   = 2'd1;
  localparam logic [1:0] StFail = 2'd2;

  localparam logic [2:0] RegBlockBytes = 3'd0;
  localparam logic [2:0] RegRespPoll   = 3'd1;
  localparam logic [2:0] RegCmdRetry   = 3'd2;
  localparam logic [2:0] RegInitRetry  = 3'd3;
  localparam logic [2:0] RegTokenWait  = 3'd4;
  localparam logic [2:0] RegWrAck      = 3'd5;
  localparam logic [2:0] RegBusyWait   = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] block_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_data;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       wr_take;
    logic [1:0] status;
    logic [3:0] error_kind;
    logic       standard_capacity;
  } rsp_t;

  typedef struct packed {
    logic [12:0] block_bytes;
    logic [7:0]  response_poll_limit;
    logic [7:0]  command_retry_limit;
    logic [11:0] init_retry_limit;
    logic [23:0] token_wait_limit;
    logic [11:0] write_ack_limit;
    logic [23:0] busy_wait_limit;
  } cfg_t;

  function automatic logic [5:0] cmd_code(phase_e p);
    unique case (p)
      P_CMD8:          return 6'd8;
      P_OCR1, P_OCR2:  return 6'd58;
      P_CMD55:         return 6'd55;
      P_ACMD41:        return 6'd41;
      P_CMD16:         return 6'd16;
      P_RD_CMD:        return 6'd17;
      P_WR_CMD:        return 6'd24;
      P_CMD13:         return 6'd13;
      default:         return 6'd0;
    endcase
  endfunction

  function automatic logic [2:0] tail_len(phase_e p);
    if (p == P_CMD8 || p == P_OCR1 || p == P_OCR2) return 3'd4;
    if (p == P_CMD13) return 3'd1;
    return 3'd0;
  endfunction

endpackage

// File: rtl/core/sdspi_cfg.sv
module sdspi_cfg #(
  parameter int unsigned MaxBlockBytes = sdspi_pkg::MaxBlockBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output sdspi_pkg::cfg_t    cfg_o,
  output logic [12:0]        blen_o
);
  sdspi_pkg::cfg_t cfg_q;
  logic [12:0]     bb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_bytes         <= 13'd512;
      cfg_q.response_poll_limit <= 8'd255;
      cfg_q.command_retry_limit <= 8'd254;
      cfg_q.init_retry_limit    <= 12'd4094;
      cfg_q.token_wait_limit    <= 24'd16777214;
      cfg_q.write_ack_limit     <= 12'd4094;
      cfg_q.busy_wait_limit     <= 24'd16777214;
    end else if (cfg_valid_i) begin
      // zero limits act as one
      unique case (cfg_index_i)
        sdspi_pkg::RegBlockBytes: cfg_q.block_bytes <= cfg_data_i[12:0];
        sdspi_pkg::RegRespPoll:
          cfg_q.response_poll_limit <= (cfg_data_i[7:0] == '0) ? 8'd1 : cfg_data_i[7:0];
        sdspi_pkg::RegCmdRetry:
          cfg_q.command_retry_limit <= (cfg_data_i[7:0] == '0) ? 8'd1 : cfg_data_i[7:0];
        sdspi_pkg::RegInitRetry:
          cfg_q.init_retry_limit <= (cfg_data_i[11:0] == '0) ? 12'd1 : cfg_data_i[11:0];
        sdspi_pkg::RegTokenWait:
          cfg_q.token_wait_limit <= (cfg_data_i == '0) ? 24'd1 : cfg_data_i;
        sdspi_pkg::RegWrAck:
          cfg_q.write_ack_limit <= (cfg_data_i[11:0] == '0) ? 12'd1 : cfg_data_i[11:0];
        sdspi_pkg::RegBusyWait:
          cfg_q.busy_wait_limit <= (cfg_data_i == '0) ? 24'd1 : cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp block length into 1..MaxBlockBytes
  always_comb begin
    bb = cfg_q.block_bytes;
    if (bb == '0) blen_o = 13'd1;
    else if (bb > 13'(MaxBlockBytes)) blen_o = 13'(MaxBlockBytes);
    else blen_o = bb;
  end

  assign cfg_o = cfg_q;
endmodule

// File: rtl/core/sd_spi_host_sequencer_top.sv
// An accepted request's response is registered and shown in the cycle after it.
// Throughput: one request per cycle while the output drains; each request is
// one SPI byte exchange, so the link sets the sustained rate.
// A full output register takes a new request only in a cycle in which it
// drains; while the consumer stalls, hold off the input.
// Reset (async, active low): phase idle, counters zero, config to defaults.
module sd_spi_host_sequencer_top #(
  parameter int unsigned MaxBlockBytes = sdspi_pkg::MaxBlockBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sdspi_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sdspi_pkg::rsp_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i
);
  sdspi_pkg::cfg_t   cfg;
  logic [12:0]       blen;

  sdspi_cfg #(.MaxBlockBytes(MaxBlockBytes)) u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg), .blen_o(blen)
  );

  // sequencer state
  sdspi_pkg::phase_e phase_q, phase_d;
  sdspi_pkg::sub_e   sub_q, sub_d;
  logic [3:0]  frame_pos_q, frame_pos_d;
  logic [12:0] data_count_q, data_count_d;
  logic [23:0] poll_count_q, poll_count_d;
  logic [11:0] retry_count_q, retry_count_d;
  logic [7:0]  last_r1_q, last_r1_d;
  logic [31:0] resp_tail_q, resp_tail_d;
  logic        is_std_q, is_std_d;
  logic [31:0] arg_q, arg_d;
  logic [7:0]  hold_tx_q, hold_tx_d;
  logic        hold_cs_q, hold_cs_d;
  logic [1:0]  done_st_q, done_st_d;
  logic [3:0]  done_err_q, done_err_d;

  sdspi_pkg::rsp_t rsp_d, rsp_q;
  logic            out_valid_q;
  logic            accept;

  // Output register: take a new request whenever it is empty or draining.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // Next-state and response logic for one byte step.
  always_comb begin
    logic [7:0]  rx;
    logic [23:0] pc1;
    logic [11:0] rc1;
    logic [3:0]  fp1;
    logic [12:0] dc1;
    logic        r1_done;
    logic [7:0]  r1v;
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] tail_n;
    logic        cmd_done;

    phase_d = phase_q; sub_d = sub_q; frame_pos_d = frame_pos_q;
    data_count_d = data_count_q; poll_count_d = poll_count_q;
    retry_count_d = retry_count_q; last_r1_d = last_r1_q;
    resp_tail_d = resp_tail_q; is_std_d = is_std_q; arg_d = arg_q;
    hold_tx_d = hold_tx_q; hold_cs_d = hold_cs_q;
    done_st_d = done_st_q; done_err_d = done_err_q;
    rsp_d = '0;

    rx  = in_data_i.rx_byte;
    pc1 = poll_count_q + 24'd1;
    rc1 = retry_count_q + 12'd1;
    fp1 = frame_pos_q + 4'd1;
    dc1 = data_count_q + 13'd1;
    r1_done = 1'b0; r1v = last_r1_q;
    cmd_done = 1'b0;
    b0 = resp_tail_q[31:24]; b1 = resp_tail_q[23:16];
    b2 = resp_tail_q[15:8];  b3 = resp_tail_q[7:0];
    tail_n = {resp_tail_q[23:0], rx};

    if (phase_q == sdspi_pkg::P_IDLE) begin
      unique case (sdspi_pkg::cmd_e'(in_data_i.cmd))
        sdspi_pkg::CMD_INIT: begin
          phase_d = sdspi_pkg::P_DUMMY; frame_pos_d = '0; retry_count_d = '0;
          rsp_d.tx_valid = 1'b1; rsp_d.tx_byte = 8'hFF; rsp_d.chip_select = 1'b0;
        end
        sdspi_pkg::CMD_READ, sdspi_pkg::CMD_WRITE: begin
          phase_d = (in_data_i.cmd == sdspi_pkg::CMD_READ) ? sdspi_pkg::P_RD_CMD
                                                           : sdspi_pkg::P_WR_CMD;
          sub_d = sdspi_pkg::S_FRAME; frame_pos_d = '0;
          arg_d = is_std_q ? {in_data_i.block_addr[22:0], 9'd0} : in_data_i.block_addr;
          rsp_d.tx_valid = 1'b1; rsp_d.chip_select = 1'b1;
          rsp_d.tx_byte = {2'b01, sdspi_pkg::cmd_code(phase_d)};
        end
        default: begin
          rsp_d.status = done_st_q; rsp_d.error_kind = done_err_q;
        end
      endcase
    end else if (in_data_i.cmd != sdspi_pkg::CMD_XFER) begin
      // repeat the pending transfer
      rsp_d.tx_valid = 1'b1; rsp_d.tx_byte = hold_tx_q; rsp_d.chip_select = hold_cs_q;
    end else begin
      rsp_d.tx_valid = 1'b1; rsp_d.tx_byte = 8'hFF; rsp_d.chip_select = 1'b1;
      unique case (phase_q)
        sdspi_pkg::P_DUMMY: begin
          frame_pos_d = fp1;
          if (fp1 < 4'd10) rsp_d.chip_select = 1'b0;
          else begin
            retry_count_d = '0; phase_d = sdspi_pkg::P_CMD0; sub_d = sdspi_pkg::S_FRAME;
            frame_pos_d = '0; arg_d = '0; rsp_d.tx_byte = 8'h40;
          end
        end
        sdspi_pkg::P_RD_TOKEN: begin
          poll_count_d = pc1;
          if (rx == 8'hFE) begin
            phase_d = sdspi_pkg::P_RD_DATA; data_count_d = '0;
          end else if (pc1 >= cfg.token_wait_limit) begin
            phase_d = sdspi_pkg::P_IDLE; done_st_d = sdspi_pkg::StFail;
            done_err_d = sdspi_pkg::E_TOKEN;
          end
        end
        sdspi_pkg::P_RD_DATA: begin
          rsp_d.rd_valid = 1'b1; rsp_d.rd_data = rx; data_count_d = dc1;
          if (dc1 >= blen) begin
            phase_d = sdspi_pkg::P_RD_CRC; frame_pos_d = '0;
          end
        end
        sdspi_pkg::P_RD_CRC: begin
          frame_pos_d = fp1;
          if (fp1 >= 4'd2) begin
            phase_d = sdspi_pkg::P_RD_END; rsp_d.chip_select = 1'b0;
          end
        end
        sdspi_pkg::P_RD_END: begin
          phase_d = sdspi_pkg::P_IDLE; done_st_d = sdspi_pkg::StOk;
          done_err_d = sdspi_pkg::E_NONE;
        end
        sdspi_pkg::P_WR_TOKEN: begin
          phase_d = sdspi_pkg::P_WR_DATA; data_count_d = '0;
          rsp_d.wr_take = 1'b1; rsp_d.tx_byte = in_data_i.wr_data;
        end
        sdspi_pkg::P_WR_DATA: begin
          data_count_d = dc1;
          if (dc1 < blen) begin
            rsp_d.wr_take = 1'b1; rsp_d.tx_byte = in_data_i.wr_data;
          end else begin
            phase_d = sdspi_pkg::P_WR_CRC; frame_pos_d = '0;
          end
        end
        sdspi_pkg::P_WR_CRC: begin
          frame_pos_d = fp1;
          if (fp1 >= 4'd2) begin
            phase_d = sdspi_pkg::P_WR_ACK; poll_count_d = '0;
          end
        end
        sdspi_pkg::P_WR_ACK: begin
          poll_count_d = pc1;
          if (rx[4:0] == 5'h05) begin
            phase_d = sdspi_pkg::P_WR_BUSY; poll_count_d = '0;
          end else if (pc1 >= 24'(cfg.write_ack_limit)) begin
            phase_d = sdspi_pkg::P_IDLE; done_st_d = sdspi_pkg::StFail;
            done_err_d = sdspi_pkg::E_WR_ACK;
          end
        end
        sdspi_pkg::P_WR_BUSY: begin
          poll_count_d = pc1;
          if (rx != 8'h00) begin
            phase_d = sdspi_pkg::P_WR_END; rsp_d.chip_select = 1'b0;
          end else if (pc1 >= cfg.busy_wait_limit) begin
            phase_d = sdspi_pkg::P_IDLE; done_st_d = sdspi_pkg::StFail;
            done_err_d = sdspi_pkg::E_WR_ACK;
          end
        end
        sdspi_pkg::P_WR_END: begin
          phase_d = sdspi_pkg::P_CMD13; sub_d = sdspi_pkg::S_FRAME;
          frame_pos_d = '0; arg_d = '0; rsp_d.tx_byte = 8'h4D;
        end
        default: begin
          // command phases: frame, R1 poll, tail, end byte
          unique case (sub_q)
            sdspi_pkg::S_FRAME: begin
              frame_pos_d = fp1;
              if (fp1 < 4'd6) begin
                unique case (fp1[2:0])
                  3'd1: rsp_d.tx_byte = arg_q[31:24];
                  3'd2: rsp_d.tx_byte = arg_q[23:16];
                  3'd3: rsp_d.tx_byte = arg_q[15:8];
                  3'd4: rsp_d.tx_byte = arg_q[7:0];
                  default:
                    rsp_d.tx_byte = (phase_q == sdspi_pkg::P_CMD0) ? 8'h95 :
                                    (phase_q == sdspi_pkg::P_CMD8) ? 8'h87 : 8'h00;
                endcase
              end else begin
                sub_d = sdspi_pkg::S_POLL; poll_count_d = '0;
              end
            end
            sdspi_pkg::S_POLL: begin
              poll_count_d = pc1;
              if (rx != 8'hFF) begin
                r1_done = 1'b1; r1v = rx;
              end else if (pc1 >= 24'(cfg.response_poll_limit)) begin
                r1_done = 1'b1; r1v = 8'hFF;
              end
              if (r1_done) begin
                last_r1_d = r1v;
                if (sdspi_pkg::tail_len(phase_q) != '0) begin
                  sub_d = sdspi_pkg::S_TAIL; frame_pos_d = '0; resp_tail_d = '0;
                end else if (phase_q == sdspi_pkg::P_RD_CMD ||
                             phase_q == sdspi_pkg::P_WR_CMD) begin
                  cmd_done = 1'b1;
                end else begin
                  sub_d = sdspi_pkg::S_END; rsp_d.chip_select = 1'b0;
                end
              end
            end
            sdspi_pkg::S_TAIL: begin
              resp_tail_d = tail_n; frame_pos_d = fp1;
              if (fp1 >= 4'({1'b0, sdspi_pkg::tail_len(phase_q)})) begin
                sub_d = sdspi_pkg::S_END; rsp_d.chip_select = 1'b0;
              end
            end
            default: cmd_done = 1'b1;
          endcase

          if (cmd_done) begin
            // evaluate the finished command against the latest R1 and tail
            logic        fin;
            logic [3:0]  ferr;
            logic        start;
            sdspi_pkg::phase_e np;
            logic [31:0] narg;
            logic [7:0]  r1;
            logic        rty;
            logic [11:0] rlim;
            fin = 1'b0; ferr = sdspi_pkg::E_NONE; start = 1'b0;
            np = phase_q; narg = arg_q; r1 = r1v; rty = 1'b0;
            rlim = 12'(cfg.command_retry_limit);
            unique case (phase_q)
              sdspi_pkg::P_CMD0: begin
                if (r1 == 8'h01) begin
                  start = 1'b1; np = sdspi_pkg::P_CMD8; narg = 32'h1AA;
                end else begin
                  rty = 1'b1; ferr = sdspi_pkg::E_CMD0;
                end
              end
              sdspi_pkg::P_CMD8: begin
                if (r1 == 8'h09) begin
                  fin = 1'b1; ferr = sdspi_pkg::E_CMD8_CRC;
                end else if (r1 == 8'h01 && b2[3:0] == 4'h1 && b3 == 8'hAA) begin
                  retry_count_d = '0; start = 1'b1; np = sdspi_pkg::P_OCR1; narg = '0;
                end else begin
                  fin = 1'b1; ferr = sdspi_pkg::E_CMD8_CHECK;
                end
              end
              sdspi_pkg::P_OCR1: begin
                if (r1 == 8'h01 && b1[4:0] != '0 && b2[7]) begin
                  retry_count_d = '0; start = 1'b1; np = sdspi_pkg::P_CMD55; narg = '0;
                end else begin
                  rty = 1'b1; ferr = sdspi_pkg::E_OCR;
                end
              end
              sdspi_pkg::P_CMD55: begin
                if (r1 != 8'h01) begin
                  fin = 1'b1; ferr = sdspi_pkg::E_CMD55;
                end else begin
                  start = 1'b1; np = sdspi_pkg::P_ACMD41; narg = 32'h4000_0000;
                end
              end
              sdspi_pkg::P_ACMD41: begin
                if (r1 == 8'h00) begin
                  retry_count_d = '0; start = 1'b1; np = sdspi_pkg::P_OCR2; narg = '0;
                end else begin
                  retry_count_d = rc1;
                  if (rc1 >= cfg.init_retry_limit) begin
                    fin = 1'b1; ferr = sdspi_pkg::E_ACMD41;
                  end else begin
                    start = 1'b1; np = sdspi_pkg::P_CMD55; narg = '0;
                  end
                end
              end
              sdspi_pkg::P_OCR2: begin
                if (r1 != 8'h00) begin
                  rty = 1'b1; ferr = sdspi_pkg::E_OCR;
                end else if (b0[6]) begin
                  fin = 1'b1;
                  if (blen != 13'd512) ferr = sdspi_pkg::E_CMD16;
                  else is_std_d = 1'b0;
                end else begin
                  retry_count_d = '0; start = 1'b1; np = sdspi_pkg::P_CMD16;
                  narg = {19'd0, blen};
                end
              end
              sdspi_pkg::P_CMD16: begin
                if (r1 == 8'h00) begin
                  is_std_d = 1'b1; fin = 1'b1;
                end else begin
                  rty = 1'b1; ferr = sdspi_pkg::E_CMD16;
                end
              end
              sdspi_pkg::P_RD_CMD: begin
                if (r1 != 8'h00) begin
                  fin = 1'b1; ferr = sdspi_pkg::E_READ_R1;
                end else begin
                  phase_d = sdspi_pkg::P_RD_TOKEN; poll_count_d = '0;
                end
              end
              sdspi_pkg::P_WR_CMD: begin
                if (r1 != 8'h00) begin
                  fin = 1'b1; ferr = sdspi_pkg::E_WR_STATUS;
                end else begin
                  phase_d = sdspi_pkg::P_WR_TOKEN; rsp_d.tx_byte = 8'hFE;
                end
              end
              default: begin
                fin = 1'b1;
                if (r1 != 8'h00 || b3 != 8'h00) ferr = sdspi_pkg::E_WR_STATUS;
              end
            endcase
            if (rty) begin
              retry_count_d = rc1;
              if (rc1 >= rlim) fin = 1'b1;
              else start = 1'b1;
            end
            if (fin) begin
              phase_d = sdspi_pkg::P_IDLE;
              done_st_d = (ferr != sdspi_pkg::E_NONE) ? sdspi_pkg::StFail : sdspi_pkg::StOk;
              done_err_d = ferr;
            end else if (start) begin
              phase_d = np; sub_d = sdspi_pkg::S_FRAME; frame_pos_d = '0; arg_d = narg;
              rsp_d.tx_byte = {2'b01, sdspi_pkg::cmd_code(np)};
              rsp_d.chip_select = 1'b1;
            end
          end
        end
      endcase

      // a finish drops the transfer and reports completion
      if (phase_d == sdspi_pkg::P_IDLE) begin
        rsp_d.tx_valid = 1'b0; rsp_d.tx_byte = '0; rsp_d.chip_select = 1'b0;
        rsp_d.status = done_st_d; rsp_d.error_kind = done_err_d;
        sub_d = sdspi_pkg::S_FRAME;
      end
    end

    if (phase_d == sdspi_pkg::P_IDLE) begin
      hold_tx_d = 8'hFF; hold_cs_d = 1'b0;
    end else if (rsp_d.tx_valid) begin
      hold_tx_d = rsp_d.tx_byte; hold_cs_d = rsp_d.chip_select;
    end
    rsp_d.standard_capacity = is_std_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::P_IDLE; sub_q <= sdspi_pkg::S_FRAME;
      frame_pos_q <= '0; data_count_q <= '0; poll_count_q <= '0;
      retry_count_q <= '0; last_r1_q <= 8'hFF; resp_tail_q <= '0;
      is_std_q <= 1'b0; arg_q <= '0; hold_tx_q <= 8'hFF; hold_cs_q <= 1'b0;
      done_st_q <= sdspi_pkg::StBusy; done_err_q <= sdspi_pkg::E_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d; sub_q <= sub_d; frame_pos_q <= frame_pos_d;
        data_count_q <= data_count_d; poll_count_q <= poll_count_d;
        retry_count_q <= retry_count_d; last_r1_q <= last_r1_d;
        resp_tail_q <= resp_tail_d; is_std_q <= is_std_d; arg_q <= arg_d;
        hold_tx_q <= hold_tx_d; hold_cs_q <= hold_cs_d;
        done_st_q <= done_st_d; done_err_q <= done_err_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rsp_q <= rsp_d;
  end

  // drop checks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o) else $error("overrun");
  a_idle_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) && phase_q == sdspi_pkg::P_IDLE |-> !out_data_o.tx_valid)
    else $error("tx while idle");
  a_busy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_valid |-> out_data_o.status == sdspi_pkg::StBusy)
    else $error("status while busy");
endmodule

// File: bench/tb_sd_spi_host_sequencer_top.sv
`timescale 1ns / 1ps

module tb_sd_spi_host_sequencer_top;
  import sdspi_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #5 clk = ~clk;

  sd_spi_host_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer predictor: a private copy of the host state and its registers.
  // ---------------------------------------------------------------------------
  cfg_t        regs;
  phase_e      ph;
  sub_e        sb;
  logic [3:0]  frame_pos;
  logic [12:0] data_count;
  logic [23:0] poll_count;
  logic [11:0] retry_count;
  logic [7:0]  last_r1;
  logic [31:0] resp_tail;
  logic        is_std;
  logic [31:0] cmd_arg;
  logic [7:0]  hold_tx;
  logic        hold_cs;
  logic [1:0]  done_status;
  err_e        done_err;
  rsp_t        step_out;

  function automatic void seq_reset();
    regs = '{block_bytes: 13'd512, response_poll_limit: 8'd255,
             command_retry_limit: 8'd254, init_retry_limit: 12'd4094,
             token_wait_limit: 24'd16777214, write_ack_limit: 12'd4094,
             busy_wait_limit: 24'd16777214};
    ph = P_IDLE; sb = S_FRAME; frame_pos = '0; data_count = '0;
    poll_count = '0; retry_count = '0; last_r1 = 8'hFF; resp_tail = '0;
    is_std = 1'b0; cmd_arg = '0; hold_tx = 8'hFF; hold_cs = 1'b0;
    done_status = StBusy; done_err = E_NONE;
  endfunction

  function automatic logic [5:0] command_index(phase_e p);
    case (p)
      P_CMD8:         return 6'd8;
      P_OCR1, P_OCR2: return 6'd58;
      P_CMD55:        return 6'd55;
      P_ACMD41:       return 6'd41;
      P_CMD16:        return 6'd16;
      P_RD_CMD:       return 6'd17;
      P_WR_CMD:       return 6'd24;
      P_CMD13:        return 6'd13;
      default:        return 6'd0;
    endcase
  endfunction

  function automatic logic [3:0] tail_bytes(phase_e p);
    if (p == P_CMD8 || p == P_OCR1 || p == P_OCR2) return 4'd4;
    if (p == P_CMD13) return 4'd1;
    return 4'd0;
  endfunction

  // A zero limit behaves as one.
  function automatic logic [23:0] floor1(logic [23:0] v);
    return (v == 0) ? 24'd1 : v;
  endfunction

  function automatic logic [12:0] blk_len();
    if (regs.block_bytes == 0) return 13'd1;
    if (regs.block_bytes > MaxBlockBytes) return 13'(MaxBlockBytes);
    return regs.block_bytes;
  endfunction

  function automatic logic [7:0] frame_out(logic [3:0] pos);
    logic [5:0] c;
    c = command_index(ph);
    case (pos)
      4'd0: return {2'b01, c};
      4'd1: return cmd_arg[31:24];
      4'd2: return cmd_arg[23:16];
      4'd3: return cmd_arg[15:8];
      4'd4: return cmd_arg[7:0];
      default: return (c == 0) ? 8'h95 : ((c == 8) ? 8'h87 : 8'h00);
    endcase
  endfunction

  function automatic void send(logic [7:0] b, logic cs);
    step_out.tx_valid = 1'b1; step_out.tx_byte = b; step_out.chip_select = cs;
    hold_tx = b; hold_cs = cs;
  endfunction

  function automatic void finish_op(err_e e);
    ph = P_IDLE; sb = S_FRAME;
    done_status = (e == E_NONE) ? StOk : StFail; done_err = e;
    step_out.tx_valid = 1'b0; step_out.tx_byte = '0; step_out.chip_select = 1'b0;
    step_out.status = done_status; step_out.error_kind = e;
    hold_tx = 8'hFF; hold_cs = 1'b0;
  endfunction

  function automatic void begin_cmd(phase_e p, logic [31:0] arg);
    ph = p; sb = S_FRAME; frame_pos = '0; cmd_arg = arg;
    send(frame_out(4'd0), 1'b1);
  endfunction

  function automatic void bump_retry(logic [23:0] limit, err_e e);
    retry_count = retry_count + 1'b1;
    if (24'(retry_count) >= floor1(limit)) finish_op(e);
    else begin_cmd(ph, cmd_arg);
  endfunction

  function automatic void response_complete();
    logic [7:0] b0, b1, b2, b3;
    {b0, b1, b2, b3} = resp_tail;
    case (ph)
      P_CMD0: begin
        if (last_r1 == 8'h01) begin_cmd(P_CMD8, 32'h1AA);
        else bump_retry(24'(regs.command_retry_limit), E_CMD0);
      end
      P_CMD8: begin
        if (last_r1 == 8'h09) finish_op(E_CMD8_CRC);
        else if (last_r1 == 8'h01 && b2[3:0] == 4'h1 && b3 == 8'hAA) begin
          retry_count = '0; begin_cmd(P_OCR1, '0);
        end else finish_op(E_CMD8_CHECK);
      end
      P_OCR1: begin
        if (last_r1 == 8'h01 && b1[4:0] != 0 && b2[7]) begin
          retry_count = '0; begin_cmd(P_CMD55, '0);
        end else bump_retry(24'(regs.command_retry_limit), E_OCR);
      end
      P_CMD55: begin
        if (last_r1 != 8'h01) finish_op(E_CMD55);
        else begin_cmd(P_ACMD41, 32'h4000_0000);
      end
      P_ACMD41: begin
        if (last_r1 == 0) begin
          retry_count = '0; begin_cmd(P_OCR2, '0);
        end else begin
          retry_count = retry_count + 1'b1;
          if (24'(retry_count) >= floor1(24'(regs.init_retry_limit))) finish_op(E_ACMD41);
          else begin_cmd(P_CMD55, '0);
        end
      end
      P_OCR2: begin
        if (last_r1 != 0) bump_retry(24'(regs.command_retry_limit), E_OCR);
        else if (b0[6]) begin
          if (blk_len() != 13'd512) finish_op(E_CMD16);
          else begin
            is_std = 1'b0; finish_op(E_NONE);
          end
        end else begin
          retry_count = '0; begin_cmd(P_CMD16, 32'(blk_len()));
        end
      end
      P_CMD16: begin
        if (last_r1 == 0) begin
          is_std = 1'b1; finish_op(E_NONE);
        end else bump_retry(24'(regs.command_retry_limit), E_CMD16);
      end
      P_RD_CMD: begin
        if (last_r1 != 0) finish_op(E_READ_R1);
        else begin
          ph = P_RD_TOKEN; poll_count = '0; send(8'hFF, 1'b1);
        end
      end
      P_WR_CMD: begin
        if (last_r1 != 0) finish_op(E_WR_STATUS);
        else begin
          ph = P_WR_TOKEN; send(8'hFE, 1'b1);
        end
      end
      default: begin
        if (last_r1 != 0 || b3 != 0) finish_op(E_WR_STATUS);
        else finish_op(E_NONE);
      end
    endcase
  endfunction

  function automatic void r1_taken();
    if (tail_bytes(ph) != 0) begin
      sb = S_TAIL; frame_pos = '0; resp_tail = '0; send(8'hFF, 1'b1);
    end else if (ph == P_RD_CMD || ph == P_WR_CMD) response_complete();
    else begin
      sb = S_END; send(8'hFF, 1'b0);
    end
  endfunction

  function automatic void command_byte(logic [7:0] rx);
    case (sb)
      S_FRAME: begin
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < 6) send(frame_out(frame_pos), 1'b1);
        else begin
          sb = S_POLL; poll_count = '0; send(8'hFF, 1'b1);
        end
      end
      S_POLL: begin
        poll_count = poll_count + 1'b1;
        if (rx != 8'hFF) begin
          last_r1 = rx; r1_taken();
        end else if (poll_count >= floor1(24'(regs.response_poll_limit))) begin
          last_r1 = 8'hFF; r1_taken();
        end else send(8'hFF, 1'b1);
      end
      S_TAIL: begin
        resp_tail = {resp_tail[23:0], rx};
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < tail_bytes(ph)) send(8'hFF, 1'b1);
        else if (ph == P_RD_CMD || ph == P_WR_CMD) response_complete();
        else begin
          sb = S_END; send(8'hFF, 1'b0);
        end
      end
      default: response_complete();
    endcase
  endfunction

  function automatic void data_byte(logic [7:0] rx, logic [7:0] wr);
    case (ph)
      P_DUMMY: begin
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < 10) send(8'hFF, 1'b0);
        else begin
          retry_count = '0; begin_cmd(P_CMD0, '0);
        end
      end
      P_RD_TOKEN: begin
        poll_count = poll_count + 1'b1;
        if (rx == 8'hFE) begin
          ph = P_RD_DATA; data_count = '0; send(8'hFF, 1'b1);
        end else if (poll_count >= floor1(regs.token_wait_limit)) finish_op(E_TOKEN);
        else send(8'hFF, 1'b1);
      end
      P_RD_DATA: begin
        step_out.rd_valid = 1'b1; step_out.rd_data = rx;
        data_count = data_count + 1'b1;
        if (data_count >= blk_len()) begin
          ph = P_RD_CRC; frame_pos = '0;
        end
        send(8'hFF, 1'b1);
      end
      P_RD_CRC: begin
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < 2) send(8'hFF, 1'b1);
        else begin
          ph = P_RD_END; send(8'hFF, 1'b0);
        end
      end
      P_RD_END: finish_op(E_NONE);
      P_WR_TOKEN: begin
        ph = P_WR_DATA; data_count = '0;
        step_out.wr_take = 1'b1; send(wr, 1'b1);
      end
      P_WR_DATA: begin
        data_count = data_count + 1'b1;
        if (data_count < blk_len()) begin
          step_out.wr_take = 1'b1; send(wr, 1'b1);
        end else begin
          ph = P_WR_CRC; frame_pos = '0; send(8'hFF, 1'b1);
        end
      end
      P_WR_CRC: begin
        frame_pos = frame_pos + 1'b1;
        if (frame_pos < 2) send(8'hFF, 1'b1);
        else begin
          ph = P_WR_ACK; poll_count = '0; send(8'hFF, 1'b1);
        end
      end
      P_WR_ACK: begin
        poll_count = poll_count + 1'b1;
        if (rx[4:0] == 5'h05) begin
          ph = P_WR_BUSY; poll_count = '0; send(8'hFF, 1'b1);
        end else if (poll_count >= floor1(24'(regs.write_ack_limit))) finish_op(E_WR_ACK);
        else send(8'hFF, 1'b1);
      end
      P_WR_BUSY: begin
        poll_count = poll_count + 1'b1;
        if (rx != 0) begin
          ph = P_WR_END; send(8'hFF, 1'b0);
        end else if (poll_count >= floor1(regs.busy_wait_limit)) finish_op(E_WR_ACK);
        else send(8'hFF, 1'b1);
      end
      default: begin_cmd(P_CMD13, '0);
    endcase
  endfunction

  // Advance the predictor by one accepted request and return its response.
  function automatic rsp_t sequence_step(req_t r);
    step_out = '0;
    if (ph == P_IDLE) begin
      if (r.cmd == CMD_INIT) begin
        ph = P_DUMMY; frame_pos = '0; retry_count = '0; send(8'hFF, 1'b0);
      end else if (r.cmd == CMD_READ || r.cmd == CMD_WRITE) begin
        begin_cmd((r.cmd == CMD_READ) ? P_RD_CMD : P_WR_CMD,
                  is_std ? {r.block_addr[22:0], 9'b0} : r.block_addr);
      end else begin
        step_out.status = done_status; step_out.error_kind = done_err;
      end
    end else if (r.cmd != CMD_XFER) begin
      // Busy: a new request is dropped and the pending byte goes out again.
      step_out.tx_valid = 1'b1; step_out.tx_byte = hold_tx;
      step_out.chip_select = hold_cs;
    end else if (ph == P_DUMMY || (ph >= P_RD_TOKEN && ph <= P_RD_END) ||
                 (ph >= P_WR_TOKEN && ph <= P_WR_END)) begin
      data_byte(r.rx_byte, r.wr_data);
    end else begin
      command_byte(r.rx_byte);
    end
    step_out.standard_capacity = is_std;
    return step_out;
  endfunction

  // ---------------------------------------------------------------------------
  // Card model for the random part: mostly plausible answers, some noise.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] card_reply();
    if ($urandom_range(0, 31) == 0) return 8'($urandom);
    if (ph == P_DUMMY || ph == P_RD_DATA || ph == P_WR_DATA) return 8'($urandom);
    case (ph)
      P_RD_TOKEN: return ($urandom_range(0, 2) == 0) ? 8'hFE : 8'hFF;
      P_WR_ACK:   return ($urandom_range(0, 1) == 0) ? 8'hE5 : 8'hFF;
      P_WR_BUSY:  return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00;
      P_RD_CRC, P_RD_END, P_WR_TOKEN, P_WR_CRC, P_WR_END: return 8'($urandom);
      default: ;
    endcase
    if (sb == S_POLL) begin
      if ($urandom_range(0, 3) == 0) return 8'hFF;
      case (ph)
        P_CMD0, P_CMD8, P_OCR1, P_CMD55: return 8'h01;
        P_ACMD41: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'h01;
        default:  return 8'h00;
      endcase
    end
    if (sb == S_TAIL) begin
      if (ph == P_CMD8) return (frame_pos == 2) ? 8'h01 : ((frame_pos == 3) ? 8'hAA : 8'h00);
      if (ph == P_CMD13) return 8'h00;
      // OCR: capacity bit random, voltage window valid.
      case (frame_pos)
        4'd0:    return ($urandom_range(0, 1) == 0) ? 8'hC0 : 8'h80;
        4'd1:    return 8'hFF;
        4'd2:    return 8'h80;
        default: return 8'h00;
      endcase
    end
    return 8'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Response checking and consumer stalls.
  // ---------------------------------------------------------------------------
  rsp_t        pending_rsp[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_sd_spi_host_sequencer_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_data);
        end else begin
          want = pending_rsp.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: want %p got %p", want, out_data);
          end
        end
      end
      // Hold ready low in bursts, except in the calm tail of the run.
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request and register drivers.
  // ---------------------------------------------------------------------------
  task automatic push_request(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t got;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = sequence_step(r);
    pending_rsp.push_back(typed ? typed_rsp : got);
    // Drop valid for a random burst now and then.
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(cfg_t c);
    logic [23:0] val;
    for (int i = 0; i < 7; i++) begin
      case (3'(i))
        RegBlockBytes: val = 24'(c.block_bytes);
        RegRespPoll:   val = 24'(c.response_poll_limit);
        RegCmdRetry:   val = 24'(c.command_retry_limit);
        RegInitRetry:  val = 24'(c.init_retry_limit);
        RegTokenWait:  val = c.token_wait_limit;
        RegWrAck:      val = 24'(c.write_ack_limit);
        default:       val = c.busy_wait_limit;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  function automatic rsp_t tx_rsp(logic [7:0] b, logic cs);
    rsp_t r;
    r = '0;
    r.tx_valid = 1'b1; r.tx_byte = b; r.chip_select = cs;
    return r;
  endfunction

  function automatic rsp_t done_rsp(logic [1:0] st, err_e e);
    rsp_t r;
    r = '0;
    r.status = st; r.error_kind = e;
    return r;
  endfunction

  typedef struct {
    cmd_e        cmd;
    logic [31:0] addr;
    logic [7:0]  rx;
    logic [7:0]  wr;
    bit          typed;
    rsp_t        want;
  } row_t;

  row_t        rows[14];
  cfg_t        plan[NumPhases];
  int unsigned budget[NumPhases];

  initial begin
    req_t        r;
    int unsigned sent;
    bit          dropped;

    seq_reset();
    // Directed: idle status, read before init, request while busy, bad read R1.
    rows[0]  = '{CMD_XFER,  32'h0,         8'h00, 8'h00, 1, done_rsp(StBusy, E_NONE)};
    rows[1]  = '{CMD_READ,  32'hFFFF_FFFF, 8'h00, 8'h00, 1, tx_rsp(8'h51, 1'b1)};
    rows[2]  = '{CMD_INIT,  32'h0,         8'hFF, 8'hFF, 1, tx_rsp(8'h51, 1'b1)};
    for (int i = 3; i < 9; i++) rows[i] = '{CMD_XFER, 32'h0, 8'hFF, 8'hFF, 0, '0};
    rows[9]  = '{CMD_XFER,  32'h0,         8'h04, 8'h00, 1, done_rsp(StFail, E_READ_R1)};
    rows[10] = '{CMD_XFER,  32'h0,         8'h00, 8'h00, 1, done_rsp(StFail, E_READ_R1)};
    rows[11] = '{CMD_WRITE, 32'h0,         8'hAA, 8'h55, 1, tx_rsp(8'h58, 1'b1)};
    rows[12] = '{CMD_READ,  32'h1234_5678, 8'h00, 8'hFF, 1, tx_rsp(8'h58, 1'b1)};
    rows[13] = '{CMD_XFER,  32'h0,         8'hFF, 8'h00, 0, '0};

    // Register settings per phase: defaults, zero limits, maximums, a saturating
    // block length, small values, then defaults for the calm tail.
    plan[0] = regs;
    plan[1] = '{13'd1, 8'd0, 8'd0, 12'd0, 24'd0, 12'd0, 24'd0};
    plan[2] = '{13'd0, 8'd255, 8'd255, 12'd4095, 24'hFFFFFF, 12'd4095, 24'hFFFFFF};
    plan[3] = '{13'd8191, 8'd3, 8'd3, 12'd5, 24'd6, 12'd4, 24'd5};
    plan[4] = '{13'd16, 8'd2, 8'd1, 12'd3, 24'd20, 12'd10, 24'd10};
    plan[5] = '{13'd512, 8'd255, 8'd254, 12'd4094, 24'd16777214, 12'd4094, 24'd16777214};
    budget  = '{400, 300, 300, 350, 300, 300};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      r.cmd = rows[i].cmd; r.block_addr = rows[i].addr;
      r.rx_byte = rows[i].rx; r.wr_data = rows[i].wr;
      push_request(r, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        drain();
        write_regs(plan[p]);
      end
      calm = (p == NumPhases - 1);
      sent = 0;
      while (sent < budget[p]) begin
        r.block_addr = $urandom;
        r.wr_data = 8'($urandom);
        dropped = 1'b0;
        if (ph == P_IDLE) begin
          case ($urandom_range(0, 9))
            0, 1, 2: r.cmd = CMD_INIT;
            3, 4, 5: r.cmd = CMD_READ;
            6, 7, 8: r.cmd = CMD_WRITE;
            default: r.cmd = CMD_XFER;
          endcase
          r.rx_byte = 8'($urandom);
        end else if ($urandom_range(0, 39) == 0) begin
          r.cmd = cmd_e'($urandom_range(0, 2));
          r.rx_byte = 8'($urandom);
          dropped = 1'b1;
        end else begin
          r.cmd = CMD_XFER;
          r.rx_byte = card_reply();
        end
        push_request(r, 1'b0, '0);
        if (!dropped) sent++;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_sd_spi_host_sequencer_top: PASS");
    end else begin
      $display("tb_sd_spi_host_sequencer_top: FAIL");
    end
    $finish;
  end

endmodule
